// ----- src/c65x_pkg.sv -----
`timescale 1ns / 1ps

package c65x_pkg;

  typedef logic [5:0] func_t;
  typedef logic [7:0] byte_t;
  typedef logic [8:0] saddr_t;

  // Operation codes
  localparam func_t FN_NOP   = 6'd0;
  localparam func_t FN_ADC   = 6'd1;
  localparam func_t FN_SBC   = 6'd2;
  localparam func_t FN_AND   = 6'd3;
  localparam func_t FN_ORA   = 6'd4;
  localparam func_t FN_EOR   = 6'd5;
  localparam func_t FN_BIT   = 6'd6;
  localparam func_t FN_CMP   = 6'd7;
  localparam func_t FN_CPX   = 6'd8;
  localparam func_t FN_CPY   = 6'd9;
  localparam func_t FN_ASL_A = 6'd10;
  localparam func_t FN_ASL_M = 6'd11;
  localparam func_t FN_LSR_A = 6'd12;
  localparam func_t FN_LSR_M = 6'd13;
  localparam func_t FN_ROL_A = 6'd14;
  localparam func_t FN_ROL_M = 6'd15;
  localparam func_t FN_ROR_A = 6'd16;
  localparam func_t FN_ROR_M = 6'd17;
  localparam func_t FN_INC   = 6'd18;
  localparam func_t FN_DEC   = 6'd19;
  localparam func_t FN_INX   = 6'd20;
  localparam func_t FN_INY   = 6'd21;
  localparam func_t FN_DEX   = 6'd22;
  localparam func_t FN_DEY   = 6'd23;
  localparam func_t FN_LDA   = 6'd24;
  localparam func_t FN_LDX   = 6'd25;
  localparam func_t FN_LDY   = 6'd26;
  localparam func_t FN_STA   = 6'd27;
  localparam func_t FN_STX   = 6'd28;
  localparam func_t FN_STY   = 6'd29;
  localparam func_t FN_TAX   = 6'd30;
  localparam func_t FN_TAY   = 6'd31;
  localparam func_t FN_TSX   = 6'd32;
  localparam func_t FN_TXA   = 6'd33;
  localparam func_t FN_TXS   = 6'd34;
  localparam func_t FN_TYA   = 6'd35;
  localparam func_t FN_PHA   = 6'd36;
  localparam func_t FN_PHP   = 6'd37;
  localparam func_t FN_PLA   = 6'd38;
  localparam func_t FN_PLP   = 6'd39;
  localparam func_t FN_CLC   = 6'd40;
  localparam func_t FN_CLD   = 6'd41;
  localparam func_t FN_CLI   = 6'd42;
  localparam func_t FN_CLV   = 6'd43;
  localparam func_t FN_SEC   = 6'd44;
  localparam func_t FN_SED   = 6'd45;
  localparam func_t FN_SEI   = 6'd46;
  localparam func_t FN_BCC   = 6'd47;
  localparam func_t FN_BCS   = 6'd48;
  localparam func_t FN_BEQ   = 6'd49;
  localparam func_t FN_BMI   = 6'd50;
  localparam func_t FN_BNE   = 6'd51;
  localparam func_t FN_BPL   = 6'd52;
  localparam func_t FN_BVC   = 6'd53;
  localparam func_t FN_BVS   = 6'd54;

  // Status bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam byte_t SP_RESET   = 8'hFD;
  localparam logic  STACK_PAGE = 1'b1;

  // Architectural registers
  typedef struct packed {
    byte_t acc;
    byte_t x;
    byte_t y;
    byte_t sp;
    byte_t p;
  } arch_t;

  // One result transaction
  typedef struct packed {
    byte_t  write_data;
    logic   mem_write;
    logic   push_write;
    saddr_t stack_addr;
    byte_t  flags_out;
    byte_t  acc_out;
    logic   branch_taken;
  } result_t;

endpackage

// ----- src/c65x_ifs.sv -----
`timescale 1ns / 1ps

// Instruction channel
interface c65x_in_if;
  logic              valid;
  logic              ready;
  c65x_pkg::func_t   func;
  c65x_pkg::byte_t   operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink   (input valid, input func, input operand, output ready);
endinterface

// Result channel
interface c65x_out_if;
  logic              valid;
  logic              ready;
  c65x_pkg::byte_t   write_data;
  logic              mem_write;
  logic              push_write;
  c65x_pkg::saddr_t  stack_addr;
  c65x_pkg::byte_t   flags_out;
  c65x_pkg::byte_t   acc_out;
  logic              branch_taken;

  modport source (output valid, output write_data, output mem_write, output push_write,
                  output stack_addr, output flags_out, output acc_out,
                  output branch_taken, input ready);
  modport sink   (input valid, input write_data, input mem_write, input push_write,
                  input stack_addr, input flags_out, input acc_out,
                  input branch_taken, output ready);
endinterface

// ----- src/c65x_alu.sv -----
`timescale 1ns / 1ps

module c65x_alu (
  input  c65x_pkg::func_t   func,
  input  c65x_pkg::byte_t   operand,
  input  c65x_pkg::arch_t   cur,
  output c65x_pkg::arch_t   nxt,
  output c65x_pkg::result_t res
);
  import c65x_pkg::*;

  // Update N and Z from a result byte
  function automatic byte_t with_nz(byte_t p, byte_t v);
    byte_t q;
    q = p;
    q[FL_Z] = (v == 8'h00);
    q[FL_N] = v[7];
    return q;
  endfunction

  // Shift or rotate by one; returns {carry out, result}
  function automatic logic [8:0] shift_one(logic left, logic rot, byte_t v, logic cin);
    logic [8:0] r;
    if (left) begin
      r = {v[7], v[6:0], rot & cin};
    end else begin
      r = {v[0], rot & cin, v[7:1]};
    end
    return r;
  endfunction

  byte_t      addend;
  logic [8:0] sum;
  logic [8:0] cmp_diff;
  byte_t      cmp_reg;
  logic [8:0] sh;
  byte_t      sh_src;
  logic       sh_left;
  logic       sh_rot;
  byte_t      wdata;
  logic       mw;
  logic       pw;
  logic       taken;

  // Shared adder for ADC and SBC
  assign addend = (func == FN_SBC) ? ~operand : operand;
  assign sum    = {1'b0, cur.acc} + {1'b0, addend} + {8'h00, cur.p[FL_C]};

  // Shared compare subtractor
  always_comb begin
    case (func)
      FN_CPX:  cmp_reg = cur.x;
      FN_CPY:  cmp_reg = cur.y;
      default: cmp_reg = cur.acc;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

  // Shared shifter; odd codes take the memory byte, even codes A
  assign sh_src  = func[0] ? operand : cur.acc;
  assign sh_left = (func == FN_ASL_A) || (func == FN_ASL_M) ||
                   (func == FN_ROL_A) || (func == FN_ROL_M);
  assign sh_rot  = (func == FN_ROL_A) || (func == FN_ROL_M) ||
                   (func == FN_ROR_A) || (func == FN_ROR_M);
  assign sh      = shift_one(sh_left, sh_rot, sh_src, cur.p[FL_C]);

  // Decode and execute
  always_comb begin
    nxt   = cur;
    wdata = 8'h00;
    mw    = 1'b0;
    pw    = 1'b0;
    taken = 1'b0;
    case (func)
      FN_ADC, FN_SBC: begin
        nxt.acc     = sum[7:0];
        nxt.p[FL_C] = sum[8];
        nxt.p[FL_V] = ~(cur.acc[7] ^ addend[7]) & (cur.acc[7] ^ sum[7]);
        nxt.p       = with_nz(nxt.p, sum[7:0]);
      end
      FN_AND: begin
        nxt.acc = cur.acc & operand;
        nxt.p   = with_nz(cur.p, cur.acc & operand);
      end
      FN_ORA: begin
        nxt.acc = cur.acc | operand;
        nxt.p   = with_nz(cur.p, cur.acc | operand);
      end
      FN_EOR: begin
        nxt.acc = cur.acc ^ operand;
        nxt.p   = with_nz(cur.p, cur.acc ^ operand);
      end
      FN_BIT: begin
        nxt.p[FL_Z] = ((cur.acc & operand) == 8'h00);
        nxt.p[FL_N] = operand[7];
        nxt.p[FL_V] = operand[6];
      end
      FN_CMP, FN_CPX, FN_CPY: begin
        nxt.p       = with_nz(cur.p, cmp_diff[7:0]);
        nxt.p[FL_C] = ~cmp_diff[8];
      end
      FN_ASL_A, FN_LSR_A, FN_ROL_A, FN_ROR_A: begin
        nxt.acc     = sh[7:0];
        nxt.p       = with_nz(cur.p, sh[7:0]);
        nxt.p[FL_C] = sh[8];
      end
      FN_ASL_M, FN_LSR_M, FN_ROL_M, FN_ROR_M: begin
        wdata       = sh[7:0];
        mw          = 1'b1;
        nxt.p       = with_nz(cur.p, sh[7:0]);
        nxt.p[FL_C] = sh[8];
      end
      FN_INC: begin
        wdata = operand + 8'd1;
        mw    = 1'b1;
        nxt.p = with_nz(cur.p, operand + 8'd1);
      end
      FN_DEC: begin
        wdata = operand - 8'd1;
        mw    = 1'b1;
        nxt.p = with_nz(cur.p, operand - 8'd1);
      end
      FN_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = with_nz(cur.p, cur.x + 8'd1);
      end
      FN_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = with_nz(cur.p, cur.y + 8'd1);
      end
      FN_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = with_nz(cur.p, cur.x - 8'd1);
      end
      FN_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = with_nz(cur.p, cur.y - 8'd1);
      end
      FN_LDA: begin
        nxt.acc = operand;
        nxt.p   = with_nz(cur.p, operand);
      end
      FN_LDX: begin
        nxt.x = operand;
        nxt.p = with_nz(cur.p, operand);
      end
      FN_LDY: begin
        nxt.y = operand;
        nxt.p = with_nz(cur.p, operand);
      end
      FN_STA: begin
        wdata = cur.acc;
        mw    = 1'b1;
      end
      FN_STX: begin
        wdata = cur.x;
        mw    = 1'b1;
      end
      FN_STY: begin
        wdata = cur.y;
        mw    = 1'b1;
      end
      FN_TAX: begin
        nxt.x = cur.acc;
        nxt.p = with_nz(cur.p, cur.acc);
      end
      FN_TAY: begin
        nxt.y = cur.acc;
        nxt.p = with_nz(cur.p, cur.acc);
      end
      FN_TSX: begin
        nxt.x = cur.sp;
        nxt.p = with_nz(cur.p, cur.sp);
      end
      FN_TXA: begin
        nxt.acc = cur.x;
        nxt.p   = with_nz(cur.p, cur.x);
      end
      FN_TXS: begin
        nxt.sp = cur.x;
      end
      FN_TYA: begin
        nxt.acc = cur.y;
        nxt.p   = with_nz(cur.p, cur.y);
      end
      FN_PHA: begin
        wdata  = cur.acc;
        pw     = 1'b1;
        nxt.sp = cur.sp - 8'd1;
      end
      FN_PHP: begin
        wdata       = cur.p;
        wdata[FL_B] = 1'b1;
        wdata[FL_U] = 1'b1;
        pw          = 1'b1;
        nxt.sp      = cur.sp - 8'd1;
        nxt.p[FL_B] = 1'b0;
        nxt.p[FL_U] = 1'b0;
      end
      FN_PLA: begin
        nxt.sp  = cur.sp + 8'd1;
        nxt.acc = operand;
        nxt.p   = with_nz(cur.p, operand);
      end
      FN_PLP: begin
        nxt.sp      = cur.sp + 8'd1;
        nxt.p       = operand;
        nxt.p[FL_U] = 1'b1;
      end
      FN_CLC: nxt.p[FL_C] = 1'b0;
      FN_CLD: nxt.p[FL_D] = 1'b0;
      FN_CLI: nxt.p[FL_I] = 1'b0;
      FN_CLV: nxt.p[FL_V] = 1'b0;
      FN_SEC: nxt.p[FL_C] = 1'b1;
      FN_SED: nxt.p[FL_D] = 1'b1;
      FN_SEI: nxt.p[FL_I] = 1'b1;
      FN_BCC: taken = ~cur.p[FL_C];
      FN_BCS: taken =  cur.p[FL_C];
      FN_BEQ: taken =  cur.p[FL_Z];
      FN_BMI: taken =  cur.p[FL_N];
      FN_BNE: taken = ~cur.p[FL_Z];
      FN_BPL: taken = ~cur.p[FL_N];
      FN_BVC: taken = ~cur.p[FL_V];
      FN_BVS: taken =  cur.p[FL_V];
      default: begin
        // NOP and unused codes leave everything as is
      end
    endcase
  end

  // Pack the result; a push addresses the slot before the decrement
  always_comb begin
    res.write_data   = wdata;
    res.mem_write    = mw;
    res.push_write   = pw;
    res.stack_addr   = pw ? {STACK_PAGE, cur.sp} : {STACK_PAGE, nxt.sp};
    res.flags_out    = nxt.p;
    res.acc_out      = nxt.acc;
    res.branch_taken = taken;
  end

endmodule

// ----- src/cpu6502_register_alu_execute_top.sv -----
// Channel   Dir  Payload                                              Handshake
// in_chan   in   func[5:0], operand[7:0]                              valid/ready
// out_chan  out  write_data, mem_write, push_write, stack_addr,       valid/ready
//                flags_out, acc_out, branch_taken
//
// One transaction per cycle sustained while out_chan is ready; a result passes the input
// register, then the result register, on its way from in_chan to out_chan.
// The loop from the A/X/Y/SP/P registers through the ALU and back to them sets that
// rate: each instruction sees the state left by the one before it.
// Synchronous reset: A, X, Y and P clear, SP goes to 0xFD, both stages empty.
// A stall on out_chan holds the result and the state; in_chan stays ready while
// the input register is empty or drains into the result register.
`timescale 1ns / 1ps

module cpu6502_register_alu_execute_top (
  input logic         clk,
  input logic         rst_n,
  c65x_in_if.sink     in_chan,
  c65x_out_if.source  out_chan
);
  import c65x_pkg::*;

  logic    in_valid_r;
  logic    in_valid_nxt;
  func_t   in_func_r;
  byte_t   in_operand_r;
  arch_t   arch_r;
  arch_t   arch_nxt;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_fire;
  logic    advance;

  // Move the held instruction into the result register when that one is free
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  c65x_alu u_alu (
    .func    (in_func_r),
    .operand (in_operand_r),
    .cur     (arch_r),
    .nxt     (arch_nxt),
    .res     (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_fire) begin
      in_func_r    <= in_chan.func;
      in_operand_r <= in_chan.operand;
    end
  end

  // Architectural state, committed together with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.acc <= 8'h00;
      arch_r.x   <= 8'h00;
      arch_r.y   <= 8'h00;
      arch_r.sp  <= SP_RESET;
      arch_r.p   <= 8'h00;
    end else if (advance) begin
      arch_r <= arch_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.write_data   = out_res_r.write_data;
  assign out_chan.mem_write    = out_res_r.mem_write;
  assign out_chan.push_write   = out_res_r.push_write;
  assign out_chan.stack_addr   = out_res_r.stack_addr;
  assign out_chan.flags_out    = out_res_r.flags_out;
  assign out_chan.acc_out      = out_res_r.acc_out;
  assign out_chan.branch_taken = out_res_r.branch_taken;

`ifndef SYNTH
  // A waiting result always mirrors the committed flags and accumulator
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.flags_out == arch_r.p) && (out_res_r.acc_out == arch_r.acc))
    else $error("result flags or accumulator differ from committed state");

  // A stalled result freezes the architectural state
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> $stable(arch_r))
    else $error("state changed while the result was stalled");

  // An empty result stage never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with an empty result register");

  // A result writes to memory or to the stack, never both, and never on a branch
  a_one_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.mem_write && out_res_r.push_write) &&
                    !(out_res_r.branch_taken && (out_res_r.mem_write ||
                                                 out_res_r.push_write)))
    else $error("conflicting write strobes");

  // Stack addresses always sit in page one
  a_stack_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.stack_addr[8])
    else $error("stack address outside the stack page");
`endif

endmodule
